>>> rtl/core/assert_macros.svh
// Assertion macros shared by the shuffle index generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define RSIG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rsig: property violated");
// Condition that must never be seen outside reset.
`define RSIG_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rsig: forbidden condition seen");
`else
`define RSIG_ASSERT(lbl, clk, rst, prop)
`define RSIG_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> rtl/core/rsig_pkg.sv
// Package for the shuffle index generator: field widths, constants,
// controller states and the command/status structs. No dependencies.
package rsig_pkg;

  localparam int FRAC_W = 16;
  localparam int DIM_W  = 7;
  localparam int POS_W  = 6;
  localparam int SRC_W  = 6;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PROBE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_frac;
    logic scale;
    logic probe_step;
    logic emit_pick;
    logic flush_skip;
    logic emit_fill;
    logic clear_perm;
  } cmd_t;

  typedef struct packed {
    logic idx_used;
    logic j_used;
    logic pick_done;
    logic pick_last;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/rsig_in_if.sv
// Request channel of the shuffle index generator: one random fraction.
// Depends on rsig_pkg for the field width.
interface rsig_in_if import rsig_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] random_fraction;

  modport source (output valid, output random_fraction, input ready);
  modport sink (input valid, input random_fraction, output ready);
endinterface

>>> rtl/core/rsig_out_if.sv
// Result channel of the shuffle index generator: one permutation entry.
// Depends on rsig_pkg for the field widths.
interface rsig_out_if import rsig_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [SRC_W-1:0] source_index;
  logic             is_random_pick;
  logic             last;

  modport source (
    output valid, output position, output source_index,
    output is_random_pick, output last, input ready
  );
  modport sink (
    input valid, input position, input source_index,
    input is_random_pick, input last, output ready
  );
endinterface

>>> rtl/core/rsig_ctrl.sv
// Controller of the shuffle index generator: sequences scaling, probing
// and the in-order fill. Depends on rsig_pkg.
module rsig_ctrl import rsig_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (!status.idx_used && status.out_free) begin
          if (status.pick_done && !status.pick_last) state_next = ST_FLUSH;
          else state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!status.j_used && status.out_free && status.fill_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_frac = in_valid;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      ST_PROBE: begin
        if (status.idx_used) begin
          cmd.probe_step = 1'b1;
        end else if (status.out_free) begin
          cmd.emit_pick  = 1'b1;
          cmd.clear_perm = status.pick_done && status.pick_last;
        end
      end
      ST_FLUSH: begin
        if (status.j_used) begin
          cmd.flush_skip = 1'b1;
        end else if (status.out_free) begin
          cmd.emit_fill  = 1'b1;
          cmd.clear_perm = status.fill_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/rsig_dp.sv
// Datapath of the shuffle index generator: size register, used map,
// scaling multiplier, probe and fill counters and the result register.
// Depends on rsig_pkg, rsig_out_if and assert_macros.svh.
`include "assert_macros.svh"

module rsig_dp import rsig_pkg::*; #(
  parameter int MAX_SIZE    = 64,
  parameter int RANDOM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [DIM_W-1:0]  cfg_write_data,
  input  logic [FRAC_W-1:0] random_fraction,
  input  cmd_t              cmd,
  output status_t           status,
  rsig_out_if.source        res
);

  localparam int SW     = $clog2(MAX_SIZE + 1);
  localparam int IW     = $clog2(MAX_SIZE);
  localparam int PW     = SW + FRAC_W;
  localparam int MASK_W = (RANDOM_BITS < FRAC_W) ? RANDOM_BITS : FRAC_W;
  localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((33'd1 << MASK_W) - 33'd1);

  logic [DIM_W-1:0]    perm_size;
  logic [MAX_SIZE-1:0] used_map;
  logic [SW-1:0]       pick_count;
  logic [SW-1:0]       pos;
  logic [SW-1:0]       j;
  logic [IW-1:0]       idx;
  logic [FRAC_W-1:0]   frac;
  logic                out_valid;
  logic [POS_W-1:0]    out_position;
  logic [SRC_W-1:0]    out_source;
  logic                out_random;
  logic                out_last;

  logic [SW-1:0] size_n;
  logic [SW-1:0] size_m1;
  logic [SW-1:0] picks;
  logic [SW-1:0] pick_inc;
  logic [SW-1:0] idx_inc;
  logic [PW-1:0] prod;
  logic [PW-1:0] scaled;
  logic [IW-1:0] idx_scaled;
  logic [IW-1:0] idx_wrap;
  logic          out_free;
  logic [5:0]    step_cmds;

  // Effective size: saturated to 1..MAX_SIZE.
  always_comb begin
    if (perm_size == '0) begin
      size_n = SW'(1);
    end else if (32'(perm_size) > MAX_SIZE) begin
      size_n = SW'(MAX_SIZE);
    end else begin
      size_n = SW'(perm_size);
    end
  end

  assign size_m1    = size_n - SW'(1);
  assign picks      = (size_n >> 1) + SW'(1);
  assign pick_inc   = pick_count + SW'(1);
  assign prod       = PW'(size_n) * PW'(frac);
  assign scaled     = prod >> RANDOM_BITS;
  assign idx_scaled = (scaled > PW'(size_m1)) ? IW'(size_m1) : IW'(scaled);
  assign idx_inc    = SW'(idx) + SW'(1);
  assign idx_wrap   = (idx_inc == size_n) ? '0 : IW'(idx_inc);
  assign out_free   = !out_valid || res.ready;

  assign status.idx_used  = used_map[idx];
  assign status.j_used    = used_map[j[IW-1:0]];
  assign status.pick_done = pick_inc >= picks;
  assign status.pick_last = pick_inc == size_n;
  assign status.fill_last = (pos + SW'(1)) == size_n;
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size  <= DIM_RESET;
      used_map   <= '0;
      pick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit_pick || cmd.emit_fill) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
      if (cfg_write_en) begin
        perm_size  <= cfg_write_data;
        used_map   <= '0;
        pick_count <= '0;
      end else if (cmd.clear_perm) begin
        used_map   <= '0;
        pick_count <= '0;
      end else begin
        if (cmd.emit_pick) begin
          used_map[idx] <= 1'b1;
          pick_count    <= pick_inc;
        end
        if (cmd.emit_fill) used_map[j[IW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frac) frac <= random_fraction & FRAC_MASK;
    if (cmd.scale) idx <= idx_scaled;
    if (cmd.probe_step) idx <= idx_wrap;
    if (cmd.emit_pick) begin
      out_position <= POS_W'(pick_count);
      out_source   <= SRC_W'(idx);
      out_random   <= 1'b1;
      out_last     <= status.pick_done && status.pick_last;
      pos          <= pick_inc;
      j            <= '0;
    end
    if (cmd.flush_skip) j <= j + SW'(1);
    if (cmd.emit_fill) begin
      out_position <= POS_W'(pos);
      out_source   <= SRC_W'(j);
      out_random   <= 1'b0;
      out_last     <= status.fill_last;
      pos          <= pos + SW'(1);
      j            <= j + SW'(1);
    end
  end

  assign res.valid          = out_valid;
  assign res.position       = out_position;
  assign res.source_index   = out_source;
  assign res.is_random_pick = out_random;
  assign res.last           = out_last;

  assign step_cmds = {cmd.load_frac, cmd.scale, cmd.probe_step,
                      cmd.emit_pick, cmd.flush_skip, cmd.emit_fill};

  `RSIG_ASSERT(a_one_cmd, clk, rst, $onehot0(step_cmds))
  `RSIG_ASSERT(a_pick_free, clk, rst, cmd.emit_pick |-> (!used_map[idx] && out_free))
  `RSIG_ASSERT(a_fill_free, clk, rst, cmd.emit_fill |-> (!used_map[j[IW-1:0]] && out_free))
  `RSIG_ASSERT(a_count_range, clk, rst, pick_count <= size_n)
  `RSIG_NEVER(a_scan_overrun, clk, rst, (cmd.flush_skip || cmd.emit_fill) && (j >= size_n))

endmodule

>>> rtl/core/random_shuffle_index_generator.sv
// Random shuffle index generator: top level joining controller and datapath.
// Depends on rsig_pkg, rsig_in_if, rsig_out_if, rsig_ctrl and rsig_dp.
// A pick is registered after the scale state, a probe past p used indices and a free result
// register. A new request is taken only in idle; the request that completes a permutation adds a
// scan of the remaining indices, one index per cycle, plus any stalls on the result channel.
// Reset sets the size register to 64, empties the used map and drops any result.

module random_shuffle_index_generator import rsig_pkg::*; #(
  parameter int MAX_SIZE    = 64,
  parameter int RANDOM_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [DIM_W-1:0] cfg_write_data,
  rsig_in_if.sink          req,
  rsig_out_if.source       res
);

  // The controller steps one request at a time through four states: it
  // takes the fraction in idle, scales it through the single multiplier,
  // probes forward one index per cycle until a free one is found, and,
  // once half the size plus one picks have been made, sweeps the used map
  // in ascending order to emit the remaining indices. The sweep and the
  // probe read the used map at separate indices, j and idx.

  cmd_t    cmd;
  status_t status;

  rsig_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The result register in the datapath lets the controller take a new
  // request while the previous result still waits to be collected.
  rsig_dp #(
    .MAX_SIZE    (MAX_SIZE),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .random_fraction (req.random_fraction),
    .cmd             (cmd),
    .status          (status),
    .res             (res)
  );

endmodule
